// File: sv/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;

  localparam logic [CpW-1:0]   ReplCode  = 21'h00003F;
  localparam logic [CpW-1:0]   MaxScalar = 21'h10FFFF;

  // Lead byte bounds
  localparam logic [ByteW-1:0] Lead2Min  = 8'hC2;
  localparam logic [ByteW-1:0] Lead2Max  = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Ovl  = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Sur  = 8'hED;
  localparam logic [ByteW-1:0] Lead4Ovl  = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Max  = 8'hF4;

  // Second byte bounds for the restricted leads
  localparam logic [ByteW-1:0] Sec3Min   = 8'hA0;
  localparam logic [ByteW-1:0] Sec3Max   = 8'h9F;
  localparam logic [ByteW-1:0] Sec4Min   = 8'h90;
  localparam logic [ByteW-1:0] Sec4Max   = 8'h8F;

  // Advance lengths
  localparam logic [LenW-1:0]  Len1 = 3'd1;
  localparam logic [LenW-1:0]  Len2 = 3'd2;
  localparam logic [LenW-1:0]  Len3 = 3'd3;
  localparam logic [LenW-1:0]  Len4 = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b3;
  } u8d_window_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] bytes_used;
  } u8d_result_t;

endpackage

// File: sv/u8d_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_decode
// Single-pass combinational decode of one four-byte window into a code point
// and an advance length.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  u8d_pkg::u8d_window_t win_i,
  output u8d_pkg::u8d_result_t res_o
);
  import u8d_pkg::*;

  logic [ByteW-1:0] b0, b1, b2, b3;
  logic             t1, t2, t3;
  logic [CpW-1:0]   cp2, cp3, cp4;
  logic [CpW-1:0]   cp;
  logic [LenW-1:0]  len;

  assign b0 = win_i.b0;
  assign b1 = win_i.b1;
  assign b2 = win_i.b2;
  assign b3 = win_i.b3;

  // Continuation bytes carry 10 in the top bits; a zero byte fails too
  assign t1 = (b1[7:6] == 2'b10);
  assign t2 = (b2[7:6] == 2'b10);
  assign t3 = (b3[7:6] == 2'b10);

  assign cp2 = {10'd0, b0[4:0], b1[5:0]};
  assign cp3 = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
  assign cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};

  always_comb begin
    cp  = ReplCode;
    len = Len1;
    if (b0[7] == 1'b0) begin
      cp = {13'd0, b0};
    end else if (b0[7:5] == 3'b110) begin
      if (!t1) begin
        len = Len2;
      end else if (b0 >= Lead2Min && b0 <= Lead2Max) begin
        cp  = cp2;
        len = Len2;
      end
    end else if (b0[7:4] == 4'b1110) begin
      if (!t1) begin
        len = Len2;
      end else if (!t2) begin
        len = Len3;
      end else if ((b0 == Lead3Ovl && b1 < Sec3Min) ||
                   (b0 == Lead3Sur && b1 > Sec3Max)) begin
        len = Len2;
      end else begin
        cp  = cp3;
        len = Len3;
      end
    end else if (b0 inside {[Lead4Ovl:Lead4Max]}) begin
      if (!t1) begin
        len = Len2;
      end else if (!t2) begin
        len = Len3;
      end else if (!t3) begin
        len = Len4;
      end else if ((b0 == Lead4Ovl && b1 < Sec4Min) ||
                   (b0 == Lead4Max && b1 > Sec4Max)) begin
        len = Len2;
      end else begin
        cp  = cp4;
        len = Len4;
      end
    end
    // Guard the scalar range
    if (cp > MaxScalar) begin
      cp = ReplCode;
    end
  end

  assign res_o.code_point = cp;
  assign res_o.bytes_used = len;

endmodule

// File: sv/utf8_codepoint_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_core
// UTF-8 decoder: one byte window in, one code point and advance out.
// ----------------------------------------------------------------------------
// A window is taken on every cycle with start_i high; busy_o never rises, so a
// new window may follow each cycle. Every window gives exactly one result through
// the input register, decode logic and result register, shown for one
// cycle with done_o high. Results cannot be held off, so the caller must take
// each one in the cycle it appears. Invalid sequences return 0x3F with
// bytes_used telling how far to advance.
module utf8_codepoint_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [u8d_pkg::ByteW-1:0]   lead_byte_i,
  input  logic [u8d_pkg::ByteW-1:0]   second_byte_i,
  input  logic [u8d_pkg::ByteW-1:0]   third_byte_i,
  input  logic [u8d_pkg::ByteW-1:0]   fourth_byte_i,
  output logic                        done_o,
  output logic [u8d_pkg::CpW-1:0]     code_point_o,
  output logic [u8d_pkg::LenW-1:0]    bytes_used_o
);
  import u8d_pkg::*;

  logic        in_vld_q, in_vld_d;
  u8d_window_t win_q, win_d;
  logic        res_vld_q, res_vld_d;
  u8d_result_t res_q, res_d;
  u8d_result_t dec_res;
  logic        accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign in_vld_d  = accept;
  assign win_d     = '{b0: lead_byte_i, b1: second_byte_i,
                       b2: third_byte_i, b3: fourth_byte_i};
  assign res_vld_d = in_vld_q;
  assign res_d     = dec_res;

  u8d_decode u_decode (
    .win_i (win_q),
    .res_o (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers: capture only when a word moves
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o       = res_vld_q;
  assign code_point_o = res_q.code_point;
  assign bytes_used_o = res_q.bytes_used;

  a_pipe_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> done_o)
    else $error("decoded word not delivered");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_o)
    else $error("result strobe without a word in flight");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (bytes_used_o >= Len1 && bytes_used_o <= Len4))
    else $error("advance out of range");

  a_single_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bytes_used_o == Len1) |-> (code_point_o <= 21'h7F))
    else $error("one-byte advance with a multi-byte code point");

  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (code_point_o <= MaxScalar))
    else $error("code point beyond scalar range");

endmodule
